// ===== rtl/core/sts_pkg.sv =====
`default_nettype none

package sts_pkg;

  localparam int MAX_TOKEN_CHARS = 1023;
  localparam int LEN_W = $clog2(MAX_TOKEN_CHARS + 1);
  localparam int LINE_W = 20;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;

  // Character codes the scanner reacts to.
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_N_UP = 8'h4E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N_LOW = 8'h6E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [2:0] {
    M_GAP   = 3'd0,
    M_NOTE  = 3'd1,
    M_WORD  = 3'd2,
    M_BRACE = 3'd3,
    M_QUOTE = 3'd4,
    M_ESC   = 3'd5,
    M_DONE  = 3'd6
  } scan_mode_t;

  typedef struct packed {
    scan_mode_t        mode;
    logic [7:0]        prev;
    logic [LEN_W-1:0]  len;
    logic [LINE_W-1:0] line;
    logic              fill;
    logic [7:0]        held;
  } scan_st_t;

  typedef struct packed {
    logic [7:0]        ch;
    logic              present;
    logic              last;
    logic [LINE_W-1:0] line;
    logic              done;
  } tok_res_t;

  localparam int MAX_RES = 3;

  // Result queue; the depth must be a power of two of at least MAX_RES.
  localparam int RES_QD = 4;
  localparam int RES_QW = $clog2(RES_QD);

  typedef struct packed {
    logic [1:0]               n;
    tok_res_t [MAX_RES-1:0]   r;
  } step_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/sts_scan.sv =====
`default_nettype none

module sts_scan
  import sts_pkg::*;
(
  input  wire scan_st_t   cur,
  input  wire logic [7:0] text_byte,
  input  wire logic       last_byte,
  input  wire logic       skip_comma,
  output scan_st_t        nxt,
  output step_res_t       res
);

  typedef struct packed {
    scan_st_t   st;
    logic [1:0] n;
    tok_res_t   r0;
    tok_res_t   r1;
  } proc_out_t;

  function automatic logic [LINE_W-1:0] line_inc(logic [LINE_W-1:0] l);
    return (l != LINE_MAX) ? l + 1'b1 : l;
  endfunction

  function automatic tok_res_t mk_res(logic [7:0] ch, logic present, logic last,
                                      logic [LINE_W-1:0] line);
    tok_res_t r;
    r.ch = ch;
    r.present = present;
    r.last = last;
    r.line = line;
    r.done = 1'b0;
    return r;
  endfunction

  // One byte of the scanner, with the byte after it as lookahead.
  function automatic proc_out_t proc(scan_st_t s, logic [7:0] c, logic has_next,
                                     logic [7:0] nx, logic skip);
    proc_out_t o;
    logic gap_path;
    logic is_gap;
    logic note;
    logic lastc;
    o.st = s;
    o.n = 2'd0;
    o.r0 = '0;
    o.r1 = '0;
    gap_path = 1'b0;
    is_gap = (c <= CH_SPACE) || (c == CH_LBRACE) || (c == CH_EQUAL) ||
             ((c == CH_COMMA) && !skip && (s.prev != CH_APOS));
    note = (c == CH_SEMI) || ((c == CH_SLASH) && has_next && (nx == CH_SLASH));
    lastc = ({1'b0, s.len} + 1'b1) >= (LEN_W+1)'(MAX_TOKEN_CHARS);
    unique case (s.mode)
      M_GAP: begin
        gap_path = 1'b1;
      end
      M_NOTE: begin
        if (c == CH_NL) begin
          o.st.line = line_inc(s.line);
          o.st.mode = M_GAP;
        end
      end
      M_WORD: begin
        if (is_gap || note) begin
          o.r0 = mk_res(8'd0, 1'b0, 1'b1, s.line);
          o.n = 2'd1;
          o.st.mode = M_GAP;
          gap_path = 1'b1;
        end else if (c == CH_RBRACE) begin
          o.st.mode = M_BRACE;
        end else begin
          o.r0 = mk_res(c, 1'b1, lastc, s.line);
          o.n = 2'd1;
          o.st.len = s.len + 1'b1;
          o.st.mode = lastc ? M_GAP : M_WORD;
        end
      end
      M_BRACE: begin
        o.r0 = mk_res(c, 1'b1, lastc, s.line);
        o.n = 2'd1;
        o.st.len = s.len + 1'b1;
        o.st.mode = lastc ? M_GAP : M_WORD;
      end
      M_QUOTE: begin
        if ((c == CH_DQUOTE) && (s.prev != CH_BSLASH)) begin
          o.r0 = mk_res(8'd0, 1'b0, 1'b1, s.line);
          o.n = 2'd1;
          o.st.mode = M_GAP;
        end else if (c == CH_BSLASH) begin
          if (has_next && ((nx == CH_N_LOW) || (nx == CH_N_UP))) begin
            o.st.mode = M_ESC;
          end
        end else begin
          o.r0 = mk_res(c, 1'b1, lastc, s.line);
          o.n = 2'd1;
          o.st.len = s.len + 1'b1;
          o.st.mode = lastc ? M_GAP : M_QUOTE;
        end
      end
      M_ESC: begin
        o.r0 = mk_res(CH_NL, 1'b1, lastc, s.line);
        o.n = 2'd1;
        o.st.len = s.len + 1'b1;
        o.st.mode = lastc ? M_GAP : M_QUOTE;
      end
      default: begin
        o.st.mode = M_GAP;
        gap_path = 1'b1;
      end
    endcase

    if (gap_path) begin
      if (is_gap) begin
        if (c == CH_NL) begin
          o.st.line = line_inc(o.st.line);
        end
      end else if (note) begin
        o.st.mode = M_NOTE;
      end else if (c == CH_DQUOTE) begin
        o.st.mode = M_QUOTE;
        o.st.len = '0;
      end else if (c == CH_RBRACE) begin
        o.st.mode = M_BRACE;
        o.st.len = '0;
      end else begin
        // First character of a plain token; the length limit is far above one.
        if (o.n == 2'd0) begin
          o.r0 = mk_res(c, 1'b1, 1'b0, o.st.line);
        end else begin
          o.r1 = mk_res(c, 1'b1, 1'b0, o.st.line);
        end
        o.n = o.n + 2'd1;
        o.st.len = LEN_W'(1);
        o.st.mode = M_WORD;
      end
    end
    o.st.prev = c;
    return o;
  endfunction

  proc_out_t p1;
  proc_out_t p2;
  scan_st_t  mid;
  tok_res_t  cand [5];
  logic      cval [5];
  logic [1:0] cnt;

  always_comb begin
    p1 = proc(cur, cur.held, 1'b1, text_byte, skip_comma);
    mid = cur.fill ? p1.st : cur;
    p2 = proc(mid, text_byte, 1'b0, 8'd0, skip_comma);

    cand[0] = p1.r0;
    cand[1] = p1.r1;
    cand[2] = p2.r0;
    cand[3] = p2.r1;
    cand[4] = mk_res(8'd0, 1'b0, 1'b1, p2.st.line);
    cval[0] = cur.fill && (p1.n != 2'd0);
    cval[1] = cur.fill && (p1.n == 2'd2);
    cval[2] = last_byte && (p2.n != 2'd0);
    cval[3] = last_byte && (p2.n == 2'd2);
    cval[4] = last_byte && ((p2.st.mode == M_WORD) || (p2.st.mode == M_BRACE) ||
                            (p2.st.mode == M_QUOTE) || (p2.st.mode == M_ESC));

    res = '0;
    cnt = 2'd0;
    nxt = cur;
    if (cur.mode == M_DONE) begin
      res.r[0] = mk_res(8'd0, 1'b0, 1'b0, cur.line);
      res.r[0].done = 1'b1;
      cnt = 2'd1;
    end else begin
      // At most three results survive, in order.
      for (int i = 0; i < 5; i++) begin
        if (cval[i] && (cnt != 2'd3)) begin
          res.r[cnt] = cand[i];
          cnt = cnt + 2'd1;
        end
      end
      if (last_byte) begin
        nxt = p2.st;
        nxt.mode = M_DONE;
        nxt.fill = 1'b0;
        if (cnt == 2'd0) begin
          res.r[0] = mk_res(8'd0, 1'b0, 1'b0, p2.st.line);
          cnt = 2'd1;
        end
        res.r[cnt - 2'd1].done = 1'b1;
      end else begin
        nxt = mid;
        nxt.held = text_byte;
        nxt.fill = 1'b1;
      end
    end
    res.n = cnt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/script_token_splitter_core.sv =====
`default_nettype none

// Script token splitter. Script text enters one byte per request on the slave side
// (tlast marks the final byte); token characters leave on the master side, each with
// the line number of its token, tlast closing a token and tuser set when tdata holds
// a real character. A byte is registered, scanned with the following byte as
// lookahead, and its zero to three results go into a four-entry result
// queue. One byte is taken per cycle as long as the queue has room for three
// results, so the sustained rate is one byte per cycle while bytes produce at most
// one result each; steps that produce two or three results are limited by the one
// result per cycle that the master side drains. After the final byte every further
// byte answers one done result until reset. skip_comma is written through cfg_we.
module script_token_splitter_core
  import sts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] token_char, [27:8] token_line,
                                           // [28] script_done, rest zero
  output logic             m_axis_tlast,
  output logic             m_axis_tuser    // char_present
);

  logic       skip_comma;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  scan_st_t   st;
  scan_st_t   st_next;
  step_res_t  step;

  tok_res_t          q [RES_QD];
  logic [RES_QW-1:0] wr_ptr;
  logic [RES_QW-1:0] rd_ptr;
  logic [RES_QW:0]   q_count;
  logic              pop;
  logic              room;
  logic              go;
  tok_res_t          head;

  assign pop = m_axis_tvalid && m_axis_tready;
  assign room = (q_count <= (RES_QW+1)'(RES_QD - MAX_RES)) ||
                ((q_count == (RES_QW+1)'(RES_QD - MAX_RES + 1)) && pop);
  assign go = in_valid && room;
  assign s_axis_tready = !in_valid || go;

  sts_scan u_scan (
    .cur        (st),
    .text_byte  (in_byte),
    .last_byte  (in_last),
    .skip_comma (skip_comma),
    .nxt        (st_next),
    .res        (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_comma <= 1'b0;
    end else if (cfg_we) begin
      skip_comma <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode <= M_GAP;
      st.prev <= '0;
      st.len <= '0;
      st.line <= LINE_W'(1);
      st.fill <= 1'b0;
      st.held <= '0;
    end else if (go) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_count <= '0;
    end else begin
      if (go) begin
        wr_ptr <= wr_ptr + RES_QW'(step.n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + RES_QW'(1);
      end
      q_count <= q_count + (go ? (RES_QW+1)'(step.n) : (RES_QW+1)'(0)) -
                 (RES_QW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < MAX_RES; i++) begin
        if (2'(i) < step.n) begin
          q[wr_ptr + RES_QW'(i)] <= step.r[i];
        end
      end
    end
  end

  assign head = q[rd_ptr];
  assign m_axis_tvalid = (q_count != '0);
  assign m_axis_tdata = {3'b000, head.done, head.line, head.ch};
  assign m_axis_tlast = head.last;
  assign m_axis_tuser = head.present;

endmodule

`default_nettype wire
